### rtl/rrl_pkg.sv
// ----------------------------------------------------------------------------
// rrl_pkg: shared types and constants of the restart rate limiter
// Phase, event and sequencer codes, configuration bundle and the queue head
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package rrl_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int TIME_BITS_DEF     = 48;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IN_WINDOW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_MS      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEVER_RESTART = 2'd3;

  localparam logic [31:0] WINDOW_MS_RST     = 32'd60000;
  localparam logic [7:0]  MAX_IN_WINDOW_RST = 8'd5;
  localparam logic [31:0] DELAY_MS_RST      = 32'd1000;

  // input event kinds
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_EXIT    = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_OUTCOME = 2'd3;

  typedef enum logic [2:0] {
    PH_STOPPED  = 3'd0,
    PH_STARTING = 3'd1,
    PH_RUNNING  = 3'd2,
    PH_WAIT     = 3'd3,
    PH_CRASH    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_CRASH   = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    EV_START      = 3'd0,
    EV_EXIT_OK    = 3'd1,
    EV_EXIT_FAIL  = 3'd2,
    EV_TICK       = 3'd3,
    EV_SPAWN_OK   = 3'd4,
    EV_SPAWN_FAIL = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_PRUNE  = 3'd1,
    BK_CHECK  = 3'd2,
    BK_SHIFT  = 3'd3,
    BK_APPEND = 3'd4
  } back_state_t;

  typedef struct packed {
    logic [31:0] window_ms;
    logic [7:0]  max_in_window;
    logic [31:0] delay_ms;
    logic        never_restart;
  } cfg_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } q_head_t;

  typedef struct packed {
    logic   busy;
    logic   pop;
    phase_t phase;
  } bk_status_t;

endpackage

### rtl/rrl_if.sv
// ----------------------------------------------------------------------------
// rrl_if: event and result channels of the restart rate limiter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rrl_in_if #(
  parameter int TIME_BITS = rrl_pkg::TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [TIME_BITS-1:0] now_ms;
  logic                 failed;

  modport source (output valid, output mode, output now_ms, output failed, input ready);
  modport sink   (input valid, input mode, input now_ms, input failed, output ready);
endinterface

interface rrl_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] unit_state;
  logic       spawn_request;
  logic [3:0] restarts_counted;
  logic [1:0] error_code;

  modport source (output valid, output unit_state, output spawn_request,
                  output restarts_counted, output error_code, input ready);
  modport sink   (input valid, input unit_state, input spawn_request,
                  input restarts_counted, input error_code, output ready);
endinterface

### rtl/restart_rate_limiter_fsm_core.sv
// ----------------------------------------------------------------------------
// restart_rate_limiter_fsm_core: supervisor of a restartable unit
// Configuration registers, event intake queue and lifecycle sequencer.
// ----------------------------------------------------------------------------
// Every event gives exactly one result. Events land in a two-entry queue and
// leave it one at a time. Start, tick, spawn outcome and clean exit events have
// their result registered when they leave the queue. A failed exit (unless
// never_restart is set), or a failed restart spawn, runs the budget check over
// the history memory, which has one read and one write port; when the history
// is full and the budget allows, the oldest entry is dropped. Results wait in
// an output register while the queue keeps taking events. Configuration is to be
// written by the user through the cfg_ port only while the block is idle; the
// block itself does not enforce this.
module restart_rate_limiter_fsm_core #(
  parameter int HISTORY_DEPTH = rrl_pkg::HISTORY_DEPTH_DEF,
  parameter int TIME_BITS     = rrl_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rrl_in_if.sink                            in_ch,
  rrl_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [rrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rrl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  rrl_pkg::cfg_t        cfg_r, cfg_nxt;
  rrl_pkg::q_head_t     head;
  logic [TIME_BITS-1:0] head_now;
  rrl_pkg::bk_status_t  status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rrl_pkg::CFG_WINDOW_MS:     cfg_nxt.window_ms     = cfg_wdata;
        rrl_pkg::CFG_MAX_IN_WINDOW: cfg_nxt.max_in_window = cfg_wdata[7:0];
        rrl_pkg::CFG_DELAY_MS:      cfg_nxt.delay_ms      = cfg_wdata;
        rrl_pkg::CFG_NEVER_RESTART: cfg_nxt.never_restart = cfg_wdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms     <= rrl_pkg::WINDOW_MS_RST;
      cfg_r.max_in_window <= rrl_pkg::MAX_IN_WINDOW_RST;
      cfg_r.delay_ms      <= rrl_pkg::DELAY_MS_RST;
      cfg_r.never_restart <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rrl_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .pop      (status.pop),
    .head     (head),
    .head_now (head_now)
  );

  rrl_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_BITS     (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .head_now (head_now),
    .status   (status),
    .out_ch   (out_ch)
  );

  // the back part only leaves idle with the result slot already drained
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> !out_ch.valid)
    else $error("result pending while the budget check runs");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    status.pop |-> head.valid)
    else $error("queue popped while empty");

  // only reset leaves crash loop
  a_crash_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.phase == rrl_pkg::PH_CRASH |=> status.phase == rrl_pkg::PH_CRASH)
    else $error("left crash loop without reset");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    status.pop && !$past(status.busy) ##1 !status.busy |-> out_ch.valid)
    else $error("event finished without a result");

endmodule

### rtl/rrl_front.sv
// ----------------------------------------------------------------------------
// rrl_front: event intake
// Accepts events, classifies them by kind and failure flag and holds them in
// a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module rrl_front #(
  parameter int TIME_BITS = rrl_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rrl_in_if.sink                in_ch,
  input  logic                  pop,
  output rrl_pkg::q_head_t      head,
  output logic [TIME_BITS-1:0]  head_now
);

  localparam int Q_DEPTH = 2;

  rrl_pkg::event_t      ev_q_r  [Q_DEPTH];
  logic [TIME_BITS-1:0] now_q_r [Q_DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           fill_r, fill_nxt;
  rrl_pkg::event_t      ev_in;
  logic                 push;

  always_comb begin
    unique case (in_ch.mode)
      rrl_pkg::MODE_START: ev_in = rrl_pkg::EV_START;
      rrl_pkg::MODE_EXIT:  ev_in = in_ch.failed ? rrl_pkg::EV_EXIT_FAIL : rrl_pkg::EV_EXIT_OK;
      rrl_pkg::MODE_TICK:  ev_in = rrl_pkg::EV_TICK;
      default:             ev_in = in_ch.failed ? rrl_pkg::EV_SPAWN_FAIL
                                                : rrl_pkg::EV_SPAWN_OK;
    endcase
  end

  assign in_ch.ready = (fill_r != 2'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  assign head.valid = (fill_r != 2'd0);
  assign head.ev    = ev_q_r[rd_ptr_r];
  assign head_now   = now_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ev_q_r[wr_ptr_r]  <= ev_in;
      now_q_r[wr_ptr_r] <= in_ch.now_ms;
    end
  end

endmodule

### rtl/rrl_back.sv
// ----------------------------------------------------------------------------
// rrl_back: lifecycle sequencer and restart history
// Carries out queued events against the unit phase, walks the history memory
// to prune old restarts or drop the oldest one, and registers the result.
// ----------------------------------------------------------------------------
module rrl_back #(
  parameter int HISTORY_DEPTH = rrl_pkg::HISTORY_DEPTH_DEF,
  parameter int TIME_BITS     = rrl_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrl_pkg::cfg_t         cfg,
  input  rrl_pkg::q_head_t      head,
  input  logic [TIME_BITS-1:0]  head_now,
  output rrl_pkg::bk_status_t   status,
  rrl_out_if.source             out_ch
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  rrl_pkg::back_state_t state_r, state_nxt;
  rrl_pkg::phase_t      phase_r, phase_nxt;
  logic                 is_restart_r, is_restart_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TIME_BITS-1:0] due_r, due_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]     kept_r, kept_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [TIME_BITS-1:0] rd_data_r;

  logic                 res_valid_r, res_valid_nxt;
  rrl_pkg::phase_t      res_phase_r, res_phase_nxt;
  logic                 res_spawn_r, res_spawn_nxt;
  logic [CNT_W-1:0]     res_count_r, res_count_nxt;
  rrl_pkg::err_t        res_err_r, res_err_nxt;

  logic [TIME_BITS-1:0] hist_mem [HISTORY_DEPTH];

  // idle decode
  logic                 out_free;
  logic                 do_pop;
  logic                 fail_path;
  rrl_pkg::phase_t      ev_phase;
  logic                 ev_spawn;
  logic                 ev_restart;
  rrl_pkg::err_t        ev_err;

  // walk and datapath
  logic                 walk_issue;
  logic                 walk_done;
  logic                 too_old;
  logic                 keep;
  logic                 budget_ok;
  logic                 hist_full;
  logic [TIME_BITS:0]   due_sum;
  logic [TIME_BITS-1:0] due_sat;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;

  assign out_free = !res_valid_r || out_ch.ready;
  assign do_pop   = (state_r == rrl_pkg::BK_IDLE) && head.valid && out_free;

  always_comb begin
    ev_phase   = phase_r;
    ev_spawn   = 1'b0;
    ev_restart = is_restart_r;
    ev_err     = rrl_pkg::ERR_NONE;
    fail_path  = 1'b0;
    unique case (head.ev)
      rrl_pkg::EV_START: begin
        if (phase_r == rrl_pkg::PH_STOPPED) begin
          ev_phase   = rrl_pkg::PH_STARTING;
          ev_restart = 1'b0;
          ev_spawn   = 1'b1;
        end else begin
          ev_err = rrl_pkg::ERR_INVALID;
        end
      end
      rrl_pkg::EV_EXIT_OK: begin
        if (phase_r == rrl_pkg::PH_RUNNING) ev_phase = rrl_pkg::PH_STOPPED;
        else ev_err = rrl_pkg::ERR_INVALID;
      end
      rrl_pkg::EV_EXIT_FAIL: begin
        if (phase_r != rrl_pkg::PH_RUNNING) ev_err = rrl_pkg::ERR_INVALID;
        else if (cfg.never_restart) ev_phase = rrl_pkg::PH_STOPPED;
        else fail_path = 1'b1;
      end
      rrl_pkg::EV_TICK: begin
        if (phase_r == rrl_pkg::PH_WAIT && head_now >= due_r) begin
          ev_phase   = rrl_pkg::PH_STARTING;
          ev_restart = 1'b1;
          ev_spawn   = 1'b1;
        end else if (phase_r == rrl_pkg::PH_CRASH) begin
          ev_err = rrl_pkg::ERR_CRASH;
        end
      end
      rrl_pkg::EV_SPAWN_OK: begin
        if (phase_r == rrl_pkg::PH_STARTING) ev_phase = rrl_pkg::PH_RUNNING;
        else ev_err = rrl_pkg::ERR_INVALID;
      end
      rrl_pkg::EV_SPAWN_FAIL: begin
        if (phase_r != rrl_pkg::PH_STARTING) ev_err = rrl_pkg::ERR_INVALID;
        else if (!is_restart_r) ev_phase = rrl_pkg::PH_STOPPED;
        else fail_path = 1'b1;
      end
      default: begin
        ev_err = rrl_pkg::ERR_INVALID;
      end
    endcase
  end

  // history walk: one read issued per cycle, registered data judged in the next cycle
  assign walk_issue = (rd_idx_r < count_r);
  assign walk_done  = !rd_vld_r && !walk_issue;
  assign too_old    = (now_r >= rd_data_r) &&
                      ((now_r - rd_data_r) > TIME_BITS'(cfg.window_ms));
  assign keep       = (state_r == rrl_pkg::BK_SHIFT) || !too_old;
  assign budget_ok  = (8'(count_r) < cfg.max_in_window);
  assign hist_full  = (count_r == CNT_W'(HISTORY_DEPTH));
  assign due_sum    = {1'b0, now_r} + (TIME_BITS + 1)'(cfg.delay_ms);
  assign due_sat    = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrl_pkg::BK_IDLE: begin
        if (do_pop && fail_path) state_nxt = rrl_pkg::BK_PRUNE;
      end
      rrl_pkg::BK_PRUNE: begin
        if (walk_done) state_nxt = rrl_pkg::BK_CHECK;
      end
      rrl_pkg::BK_CHECK: begin
        if (!budget_ok) state_nxt = rrl_pkg::BK_IDLE;
        else if (hist_full) state_nxt = rrl_pkg::BK_SHIFT;
        else state_nxt = rrl_pkg::BK_APPEND;
      end
      rrl_pkg::BK_SHIFT: begin
        if (walk_done) state_nxt = rrl_pkg::BK_APPEND;
      end
      rrl_pkg::BK_APPEND: begin
        state_nxt = rrl_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = rrl_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt      = phase_r;
    is_restart_nxt = is_restart_r;
    count_nxt      = count_r;
    due_nxt        = due_r;
    now_nxt        = now_r;
    rd_idx_nxt     = rd_idx_r;
    kept_nxt       = kept_r;
    rd_vld_nxt     = 1'b0;
    res_valid_nxt  = out_ch.ready ? 1'b0 : res_valid_r;
    res_phase_nxt  = res_phase_r;
    res_spawn_nxt  = res_spawn_r;
    res_count_nxt  = res_count_r;
    res_err_nxt    = res_err_r;
    mem_we         = 1'b0;
    mem_waddr      = kept_r[IDX_W-1:0];
    mem_wdata      = rd_data_r;
    unique case (state_r)
      rrl_pkg::BK_IDLE: begin
        if (do_pop) begin
          if (fail_path) begin
            now_nxt    = head_now;
            rd_idx_nxt = '0;
            kept_nxt   = '0;
          end else begin
            phase_nxt      = ev_phase;
            is_restart_nxt = ev_restart;
            res_valid_nxt  = 1'b1;
            res_phase_nxt  = ev_phase;
            res_spawn_nxt  = ev_spawn;
            res_count_nxt  = count_r;
            res_err_nxt    = ev_err;
          end
        end
      end
      rrl_pkg::BK_PRUNE,
      rrl_pkg::BK_SHIFT: begin
        rd_vld_nxt = walk_issue;
        if (walk_issue) rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_vld_r && keep) begin
          mem_we   = 1'b1;
          kept_nxt = kept_r + 1'b1;
        end
        // compaction shortens the history once the walk ends
        if (walk_done && state_r == rrl_pkg::BK_PRUNE) count_nxt = kept_r;
      end
      rrl_pkg::BK_CHECK: begin
        if (!budget_ok) begin
          phase_nxt     = rrl_pkg::PH_CRASH;
          res_valid_nxt = 1'b1;
          res_phase_nxt = rrl_pkg::PH_CRASH;
          res_spawn_nxt = 1'b0;
          res_count_nxt = count_r;
          res_err_nxt   = rrl_pkg::ERR_CRASH;
        end else if (hist_full) begin
          // drop the oldest entry by copying the rest down one place
          rd_idx_nxt = CNT_W'(1);
          kept_nxt   = '0;
        end
      end
      rrl_pkg::BK_APPEND: begin
        mem_we        = 1'b1;
        mem_wdata     = now_r;
        count_nxt     = kept_r + 1'b1;
        due_nxt       = due_sat;
        phase_nxt     = rrl_pkg::PH_WAIT;
        res_valid_nxt = 1'b1;
        res_phase_nxt = rrl_pkg::PH_WAIT;
        res_spawn_nxt = 1'b0;
        res_count_nxt = kept_r + 1'b1;
        res_err_nxt   = rrl_pkg::ERR_NONE;
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rrl_pkg::BK_IDLE;
      phase_r      <= rrl_pkg::PH_STOPPED;
      is_restart_r <= 1'b0;
      count_r      <= '0;
      due_r        <= '0;
      rd_vld_r     <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      is_restart_r <= is_restart_nxt;
      count_r      <= count_nxt;
      due_r        <= due_nxt;
      rd_vld_r     <= rd_vld_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    rd_idx_r    <= rd_idx_nxt;
    kept_r      <= kept_nxt;
    res_phase_r <= res_phase_nxt;
    res_spawn_r <= res_spawn_nxt;
    res_count_r <= res_count_nxt;
    res_err_r   <= res_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    if (walk_issue) rd_data_r <= hist_mem[rd_idx_r[IDX_W-1:0]];
  end

  assign out_ch.valid            = res_valid_r;
  assign out_ch.unit_state       = res_phase_r;
  assign out_ch.spawn_request    = res_spawn_r;
  assign out_ch.restarts_counted = 4'(res_count_r);
  assign out_ch.error_code       = res_err_r;

  assign status.busy  = (state_r != rrl_pkg::BK_IDLE);
  assign status.pop   = do_pop;
  assign status.phase = phase_r;

endmodule
